// ===== rtl/core/ket_pkg.sv =====
// shared types, constants and key code decode for the key event tracker
`timescale 1ns / 1ps

package ket_pkg;

    localparam int unsigned GridCols = 14;
    localparam int unsigned GridRows = 4;
    localparam int unsigned GridKeys = GridCols * GridRows;
    localparam int unsigned KeyIdxW  = $clog2(GridKeys);
    localparam int unsigned ColW     = 4;
    localparam int unsigned RowW     = 2;
    localparam int unsigned CodeW    = 7;
    localparam int unsigned MatCols  = 10;
    localparam int unsigned MatRows  = 13;

    localparam logic [0:0] OpKeyEvent = 1'b0;
    localparam logic [0:0] OpOverflow = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch raw event word
        logic start_scan;  // copy held set to scan register and clear it
        logic do_evt;      // decode latched event, update held set, emit
        logic do_scan;     // one scan step over the held set
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
        logic pend_empty;  // nothing left to release
    } t_sts;

    typedef struct packed {
        logic            ok;
        logic [ColW-1:0] col;
        logic [RowW-1:0] row;
    } t_key;

    // code minus one split by ten into matrix row q and column r
    function automatic t_key ket_decode(input logic [CodeW-1:0] code);
        t_key            k;
        logic [CodeW-1:0] idx;
        logic [3:0]      q;
        logic [3:0]      r;
        logic [4:0]      c;
        idx = code - CodeW'(1);
        q   = '0;
        for (int j = 1; j < MatRows; j++) begin
            if (idx >= CodeW'(MatCols * j)) begin
                q = 4'(j);
            end
        end
        r     = 4'(idx - CodeW'(q) * CodeW'(MatCols));
        c     = {q, 1'b0} + ((r > 4'd3) ? 5'd1 : 5'd0);
        k.ok  = (code != '0) && (c < 5'(GridCols));
        k.col = c[ColW-1:0];
        k.row = r[RowW-1:0];
        return k;
    endfunction

endpackage

// ===== rtl/core/key_event_tracker_unit.sv =====
// top level of the key event tracker
`timescale 1ns / 1ps

// key event tracker: keeps the set of held keys of a 4 by 14 key grid
// input channel: i_valid / o_stall carries one word (i_operation, i_raw_event)
//   operation 0 is a raw key event: bit 7 pressed, bits 6..0 key code from 1
//   operation 1 is an overflow notice: every held key is released
// output channel: o_valid / i_stall carries one word per reported key
//   (o_key_column, o_key_row, o_pressed, o_last_of_run)
// a raw event is latched at accept and decoded in S_EVT once the output register
//   is free, then lands in the output register; a zero code or a key off the
//   grid gives no word and the block goes back to idle
// an overflow copies the held set into a shift register and clears it, then
//   walks one bit per cycle, while the output register is free, up to the
//   highest held key, back to idle once the shift register is empty; one release
//   word per held key in ascending bit order, last_of_run on the final
// the scan advances only while the output register is free, so a stall on
//   the output side holds the walk in place; o_stall is high until the current
//   word is finished, while the output register may still hold an earlier word
// synchronous active-low reset empties the held set and drops o_valid

module key_event_tracker_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic [7:0]                  i_raw_event,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ket_pkg::ColW-1:0]    o_key_column,
    output logic [ket_pkg::RowW-1:0]    o_key_row,
    output logic                        o_pressed,
    output logic                        o_last_of_run
);

    ket_pkg::t_cmd cmd;
    ket_pkg::t_sts sts;

    // sequencing of event and scan work
    ket_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // held set, decode and output register
    ket_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_raw_event   (i_raw_event),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_key_column  (o_key_column),
        .o_key_row     (o_key_row),
        .o_pressed     (o_pressed),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== rtl/core/ket_ctrl.sv =====
// controller state machine for the key event tracker
`timescale 1ns / 1ps

module ket_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_operation,
    output logic            o_stall,
    input  ket_pkg::t_sts   i_sts,
    output ket_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVT  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation == ket_pkg::OpOverflow) begin
                        o_cmd.start_scan = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_EVT;
                    end
                end
            end
            S_EVT: begin
                if (i_sts.out_free) begin
                    o_cmd.do_evt = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.out_free) begin
                    if (i_sts.pend_empty) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.do_scan = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && i_sts.out_free && i_sts.pend_empty |=> (r_state == S_IDLE))
        else $error("scan did not end on empty set");
`endif

endmodule

// ===== rtl/core/ket_dp.sv =====
// datapath for the key event tracker: held set, scan register, output register
`timescale 1ns / 1ps

module ket_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ket_pkg::t_cmd               i_cmd,
    output ket_pkg::t_sts               o_sts,
    input  logic [7:0]                  i_raw_event,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [ket_pkg::ColW-1:0]    o_key_column,
    output logic [ket_pkg::RowW-1:0]    o_key_row,
    output logic                        o_pressed,
    output logic                        o_last_of_run
);

    logic [ket_pkg::GridKeys-1:0] r_held;
    logic [ket_pkg::GridKeys-1:0] n_held;
    logic [ket_pkg::GridKeys-1:0] r_pend;
    logic [7:0]                   r_event;
    logic [ket_pkg::ColW-1:0]     r_scol;
    logic [ket_pkg::RowW-1:0]     r_srow;
    logic                         r_ov;
    logic                         n_ov;
    logic [ket_pkg::ColW-1:0]     r_col;
    logic [ket_pkg::RowW-1:0]     r_row;
    logic                         r_down;
    logic                         r_last;
    ket_pkg::t_key                dec;
    logic [ket_pkg::KeyIdxW-1:0]  bidx;
    logic                         ld_evt;
    logic                         ld_scan;

    assign dec     = ket_pkg::ket_decode(r_event[ket_pkg::CodeW-1:0]);
    assign bidx    = ket_pkg::KeyIdxW'(dec.row) * ket_pkg::KeyIdxW'(ket_pkg::GridCols)
                   + ket_pkg::KeyIdxW'(dec.col);
    assign ld_evt  = i_cmd.do_evt && dec.ok;
    assign ld_scan = i_cmd.do_scan && r_pend[0];

    assign o_sts.out_free   = !r_ov || !i_stall;
    assign o_sts.pend_empty = (r_pend == '0);

    always_comb begin
        n_held = r_held;
        if (i_cmd.start_scan) begin
            n_held = '0;
        end else if (ld_evt) begin
            n_held[bidx] = r_event[7];
        end
    end

    always_comb begin
        n_ov = r_ov;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        if (ld_evt || ld_scan) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pend <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_held <= n_held;
            r_ov   <= n_ov;
            if (i_cmd.start_scan) begin
                r_pend <= r_held;
            end else if (i_cmd.do_scan) begin
                r_pend <= r_pend >> 1;
            end
        end
    end

    // scan position and event latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_event <= i_raw_event;
        end
        if (i_cmd.start_scan) begin
            r_scol <= '0;
            r_srow <= '0;
        end else if (i_cmd.do_scan) begin
            if (r_scol == ket_pkg::ColW'(ket_pkg::GridCols - 1)) begin
                r_scol <= '0;
                r_srow <= r_srow + 1'b1;
            end else begin
                r_scol <= r_scol + 1'b1;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (ld_evt) begin
            r_col  <= dec.col;
            r_row  <= dec.row;
            r_down <= r_event[7];
            r_last <= 1'b1;
        end else if (ld_scan) begin
            r_col  <= r_scol;
            r_row  <= r_srow;
            r_down <= 1'b0;
            r_last <= (r_pend[ket_pkg::GridKeys-1:1] == '0);
        end
    end

    assign o_valid       = r_ov;
    assign o_key_column  = r_col;
    assign o_key_row     = r_row;
    assign o_pressed     = r_down;
    assign o_last_of_run = r_last;

`ifndef SYNTH
    a_held_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_scan |=> (r_held == '0))
        else $error("held set not cleared by overflow");
    a_evt_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_evt || i_cmd.do_scan) |-> o_sts.out_free)
        else $error("output word overwritten");
    a_scan_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_scan |=> (r_ov && !r_down))
        else $error("scan hit not emitted as release");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the key event tracker: random key traffic against a scoreboard
`timescale 1ns / 1ps

module testbench;

    localparam logic [7:0] PressFlag    = 8'h80;
    localparam logic [7:0] CodeMask     = 8'h7F;
    localparam int         LastGridCode = 70;
    localparam int         HoldOffLen   = 300;
    localparam int         DrainCycles  = 100;
    localparam int         StuckLimit   = 3000;

    typedef struct packed {
        logic [ket_pkg::ColW-1:0] col;
        logic [ket_pkg::RowW-1:0] row;
        logic                     pressed;
        logic                     last;
    } t_key_report;

    // tracks the held set and the key reports it still owes
    class t_key_report_board;
        logic [ket_pkg::GridKeys-1:0] held_set;
        t_key_report                  due[$];

        function new();
            held_set = '0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // work out the reports caused by one accepted word
        function void note_word(logic op, logic [7:0] ev);
            t_key_report                  rep;
            logic [ket_pkg::GridKeys-1:0] left;
            int                           code;
            int                           idx;
            int                           q;
            int                           rem;
            int                           col;
            int                           row;
            if (op == ket_pkg::OpOverflow) begin
                // release every held key, lowest index first
                left     = held_set;
                held_set = '0;
                for (int k = 0; k < ket_pkg::GridKeys; k++) begin
                    if (left[k]) begin
                        left[k]     = 1'b0;
                        rep.col     = ket_pkg::ColW'(k % ket_pkg::GridCols);
                        rep.row     = ket_pkg::RowW'(k / ket_pkg::GridCols);
                        rep.pressed = 1'b0;
                        rep.last    = (left == '0);
                        due.push_back(rep);
                    end
                end
                return;
            end
            code = int'(ev & CodeMask);
            if (code == 0) begin
                return;
            end
            idx = code - 1;
            q   = idx / 10;
            rem = idx % 10;
            col = q * 2 + ((rem > 3) ? 1 : 0);
            row = rem % 4;
            // codes past the last grid column are dropped
            if (col >= ket_pkg::GridCols) begin
                return;
            end
            held_set[row * ket_pkg::GridCols + col] = ev[7];
            rep.col     = ket_pkg::ColW'(col);
            rep.row     = ket_pkg::RowW'(row);
            rep.pressed = ev[7];
            rep.last    = 1'b1;
            due.push_back(rep);
        endfunction

        // compare one output word with the oldest report owed
        function bit check_report(t_key_report got, output string why);
            t_key_report want;
            if (due.size() == 0) begin
                why = $sformatf("unexpected word col %0d row %0d pressed %0b last %0b",
                                got.col, got.row, got.pressed, got.last);
                return 1'b0;
            end
            want = due.pop_front();
            why  = "";
            if (got.col !== want.col) begin
                why = {why, $sformatf(" col %0d want %0d", got.col, want.col)};
            end
            if (got.row !== want.row) begin
                why = {why, $sformatf(" row %0d want %0d", got.row, want.row)};
            end
            if (got.pressed !== want.pressed) begin
                why = {why, $sformatf(" pressed %0b want %0b", got.pressed, want.pressed)};
            end
            if (got.last !== want.last) begin
                why = {why, $sformatf(" last %0b want %0b", got.last, want.last)};
            end
            return (why == "");
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_operation;
    logic [7:0]                 i_raw_event;
    logic                       o_valid;
    logic                       i_stall;
    logic [ket_pkg::ColW-1:0]   o_key_column;
    logic [ket_pkg::RowW-1:0]   o_key_row;
    logic                       o_pressed;
    logic                       o_last_of_run;

    t_key_report_board   board = new();
    int                  mismatches = 0;
    int                  stuck_cycles = 0;
    bit                  tx_idle_en = 1'b1;
    bit                  rx_idle_en = 1'b1;
    bit                  hold_start = 1'b0;
    int                  hold_left = 0;
    int                  rx_burst = 0;
    string               why;
    t_key_report         seen;

    key_event_tracker_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_raw_event   (i_raw_event),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_key_column  (o_key_column),
        .o_key_row     (o_key_row),
        .o_pressed     (o_pressed),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t:%s", $time, what);
        mismatches++;
    endtask

    // monitor: both channels sampled at the rising edge, plus the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_word(i_operation, i_raw_event);
            end
            if (o_valid && !i_stall) begin
                seen = {o_key_column, o_key_row, o_pressed, o_last_of_run};
                if (!board.check_report(seen, why)) begin
                    report_mismatch(why);
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= StuckLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, or one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_left  = HoldOffLen;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_burst = $urandom_range(1, 9) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // offer one word, called at a falling edge, returns at the falling edge after accept
    task automatic send_word(input logic op, input logic [7:0] ev);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= op;
        i_raw_event <= ev;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // mostly grid key events, some overflows, some codes the block drops
    task automatic send_random_words(input int count);
        int         roll;
        logic [7:0] ev;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            ev   = 8'($urandom_range(0, 255));
            if (roll < 8) begin
                send_word(ket_pkg::OpOverflow, ev);
            end else if (roll < 18) begin
                if ($urandom_range(0, 2) == 0) begin
                    ev[6:0] = '0;
                end else begin
                    ev[6:0] = 7'($urandom_range(LastGridCode + 1, 127));
                end
                send_word(ket_pkg::OpKeyEvent, ev);
            end else begin
                ev[6:0] = 7'($urandom_range(1, LastGridCode));
                ev[7]   = ($urandom_range(0, 99) < 55);
                send_word(ket_pkg::OpKeyEvent, ev);
            end
        end
    endtask

    task automatic wait_for_reports();
        while (board.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic send_directed_words();
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd1);    // first grid key
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd70);   // last grid key
        send_word(ket_pkg::OpKeyEvent, PressFlag);           // zero code, pressed
        send_word(ket_pkg::OpKeyEvent, 8'h00);               // zero code, released
        send_word(ket_pkg::OpKeyEvent, 8'd71);               // first code off the grid
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd71);
        send_word(ket_pkg::OpKeyEvent, 8'hFF);               // highest code
        send_word(ket_pkg::OpKeyEvent, 8'h7F);
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd1);    // repeated press
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd5);
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd10);
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd11);
        send_word(ket_pkg::OpKeyEvent, 8'd1);                // release
        send_word(ket_pkg::OpKeyEvent, 8'd1);                // repeated release
        send_word(ket_pkg::OpOverflow, 8'hFF);               // releases held keys
        send_word(ket_pkg::OpOverflow, 8'h00);               // nothing held
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd16);
        send_word(ket_pkg::OpKeyEvent, PressFlag | 8'd9);    // same key as code 5
        send_word(ket_pkg::OpKeyEvent, 8'd5);
        send_word(ket_pkg::OpOverflow, 8'hAA);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = ket_pkg::OpKeyEvent;
        i_raw_event = '0;
        i_stall     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_directed_words();
        send_random_words(100);

        // long receiver hold-off while the sender keeps offering back to back
        tx_idle_en = 1'b0;
        hold_start = 1'b1;
        while (!i_stall) begin
            @(negedge i_clk);
        end
        send_random_words(20);
        tx_idle_en = 1'b1;

        // sender pauses until every report is in
        i_valid <= 1'b0;
        wait_for_reports();
        repeat (DrainCycles) @(negedge i_clk);

        // hold every key of the grid, then one overflow releases all of them
        for (int c = 1; c <= LastGridCode; c++) begin
            send_word(ket_pkg::OpKeyEvent, PressFlag | 8'(c));
        end
        send_word(ket_pkg::OpOverflow, 8'h5A);

        send_random_words(80);

        // last stretch without idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_words(40);
        i_valid <= 1'b0;

        wait_for_reports();
        repeat (DrainCycles) @(negedge i_clk);
        if (board.pending() != 0) begin
            report_mismatch($sformatf(" %0d reports never came", board.pending()));
        end
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
